### src/ipp_pkg.sv
// ----------------------------------------------------------------------------
// ipp_pkg
// Shared types and constants of the input packet parser.
// ----------------------------------------------------------------------------
package ipp_pkg;

  localparam logic [7:0] MAGIC_C = 8'h43;
  localparam logic [7:0] MAGIC_S = 8'h53;
  localparam logic [7:0] AXIS_INVALID = 8'h80;

  localparam int unsigned NUM_REGS = 5;
  localparam logic [2:0] REG_VERSION = 3'd0;
  localparam logic [2:0] REG_KIND    = 3'd1;
  localparam logic [2:0] REG_PLAYER  = 3'd2;
  localparam logic [2:0] REG_WEAPON  = 3'd3;
  localparam logic [2:0] REG_COMMAND = 3'd4;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_SHORT     = 3'd1,
    ST_BAD_ID    = 3'd2,
    ST_BAD_FIELD = 3'd3,
    ST_BAD_CMD   = 3'd4,
    ST_SEQUENCE  = 3'd5,
    ST_LONG      = 3'd6
  } status_t;

  // One result item, packed as on the output tdata (last field lowest).
  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  weapon_code;
    logic [3:0]  button_bits;
    logic [15:0] pitch_code;
    logic [15:0] yaw_code;
    logic [7:0]  strafe_code;
    logic [7:0]  forward_code;
    logic [7:0]  count_field;
    logic [7:0]  player_number;
    logic [31:0] second_word;
    logic [31:0] first_word;
  } result_t;

  localparam int unsigned RESULT_W = $bits(result_t);

endpackage

### src/input_packet_parser_unit.sv
// ----------------------------------------------------------------------------
// input_packet_parser_unit
// Streaming parser of little-endian input packets with command records and
// an end-of-packet verdict.
// ----------------------------------------------------------------------------
// Takes one packet byte per clock cycle; each byte is checked and parsed in
// the cycle it is accepted, and its results (a command record, a verdict or
// both) go into a four-entry queue that feeds the output port. The input
// stalls only while fewer than two queue slots are free, so a slow consumer
// is absorbed for a few beats. Results are registered into the queue.
// ----------------------------------------------------------------------------
module input_packet_parser_unit import ipp_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [7:0]   cfg_data,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,   // data_byte
  input  logic         in_tlast,   // end_of_packet
  output logic         out_tvalid,
  input  logic         out_tready,
  // first_word, second_word, player_number, count_field, forward_code,
  // strafe_code, yaw_code, pitch_code, button_bits, weapon_code, status, pad
  output logic [143:0] out_tdata,
  output logic         out_tuser   // is_verdict
);

  logic [1:0] q_space, push_n;
  logic       push0_verdict;
  result_t    push0, push1, item;

  ipp_front u_front (
    .clk, .rst_n, .cfg_we, .cfg_index, .cfg_data,
    .byte_valid(in_tvalid), .byte_ready(in_tready),
    .data_byte(in_tdata), .end_of_packet(in_tlast),
    .q_space, .push_n, .push0, .push0_verdict, .push1
  );

  ipp_queue u_queue (
    .clk, .rst_n, .push_n, .push0, .push0_verdict, .push1,
    .space(q_space), .out_valid(out_tvalid), .out_ready(out_tready),
    .out_item(item), .out_verdict(out_tuser)
  );

  assign out_tdata = {{(144 - RESULT_W){1'b0}}, item};

`ifndef ASSERT_OFF
  a_no_accept_full: assert property (@(posedge clk) disable iff (!rst_n)
    (q_space != 2'd2) |-> !in_tready) else $error("accept without queue room");
  a_pair_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    (push_n == 2'd2) |-> (in_tvalid && in_tready && in_tlast))
    else $error("two results without end of packet");
  a_last_pushes: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_tlast) |-> (push_n != 2'd0))
    else $error("end of packet without verdict");
`endif

endmodule

### src/ipp_front.sv
// ----------------------------------------------------------------------------
// ipp_front
// Byte parser: walks header and commands, checks fields, emits up to two
// result items per byte into the queue.
// ----------------------------------------------------------------------------
module ipp_front import ipp_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_we,
  input  logic [2:0]    cfg_index,
  input  logic [7:0]    cfg_data,
  input  logic          byte_valid,
  output logic          byte_ready,
  input  logic [7:0]    data_byte,
  input  logic          end_of_packet,
  input  logic [1:0]    q_space,
  output logic [1:0]    push_n,
  output result_t       push0,
  output logic          push0_verdict,
  output result_t       push1
);

  typedef enum logic [1:0] {PH_HEADER, PH_COMMANDS, PH_TRAILING} phase_t;

  logic [7:0]  version_r, kind_r, player_lim_r, weapon_lim_r, command_lim_r;
  phase_t      phase_r;
  logic [3:0]  off_r;
  logic [7:0]  cmd_num_r;
  logic [31:0] prev_seq_r, newest_r, ack_r;
  logic [7:0]  player_r, count_r;
  logic [119:0] asm_r;
  logic [2:0]  err_r;

  logic        fire;
  logic [2:0]  err_nxt;
  logic [2:0]  hit;
  logic        cmd_done, finish;
  logic [31:0] seq, tick;
  logic [7:0]  fwd, strf, buttons, weapon;
  logic [15:0] yaw, pitch;
  logic [31:0] newest_nxt, ack_nxt;
  logic [7:0]  player_nxt, count_nxt;
  logic        in_trailing;
  result_t     rec, vrd;

  // Two free slots cover the worst case of record plus verdict.
  assign byte_ready = (q_space == 2'd2);
  assign fire = byte_valid && byte_ready;

  // Assemble the finished command with the current byte as its top byte.
  assign seq    = asm_r[31:0];
  assign tick   = asm_r[63:32];
  assign fwd    = asm_r[71:64];
  assign strf   = asm_r[79:72];
  assign yaw    = asm_r[95:80];
  assign pitch  = asm_r[111:96];
  assign buttons = asm_r[119:112];
  assign weapon = data_byte;

  always_comb begin
    hit = ST_OK;
    newest_nxt = newest_r;
    ack_nxt = ack_r;
    player_nxt = player_r;
    count_nxt = count_r;
    cmd_done = 1'b0;
    finish = 1'b0;
    case (phase_r)
      PH_HEADER: begin
        case (off_r)
          4'd0: if (data_byte != MAGIC_C) hit = ST_BAD_ID;
          4'd1: if (data_byte != MAGIC_S) hit = ST_BAD_ID;
          4'd2: if (data_byte != version_r) hit = ST_BAD_ID;
          4'd3: if (data_byte != kind_r) hit = ST_BAD_ID;
          4'd4: begin
            player_nxt = data_byte;
            if (data_byte >= player_lim_r) hit = ST_BAD_FIELD;
          end
          4'd5: begin
            count_nxt = data_byte;
            if (data_byte == 8'd0 || data_byte > command_lim_r) hit = ST_BAD_FIELD;
          end
          4'd6, 4'd7: if (data_byte != 8'd0) hit = ST_BAD_FIELD;
          4'd8:  newest_nxt[7:0]   = data_byte;
          4'd9:  newest_nxt[15:8]  = data_byte;
          4'd10: newest_nxt[23:16] = data_byte;
          4'd11: newest_nxt[31:24] = data_byte;
          4'd12: ack_nxt[7:0]   = data_byte;
          4'd13: ack_nxt[15:8]  = data_byte;
          4'd14: ack_nxt[23:16] = data_byte;
          default: ack_nxt[31:24] = data_byte;
        endcase
        if (off_r == 4'hF && count_r == 8'd0) finish = 1'b1;
      end
      PH_COMMANDS: begin
        if (off_r == 4'hF) begin
          cmd_done = 1'b1;
          if (weapon >= weapon_lim_r || buttons[7:4] != 4'd0 ||
              fwd == AXIS_INVALID || strf == AXIS_INVALID)
            hit = ST_BAD_CMD;
          else if (seq == 32'd0 || seq <= prev_seq_r || seq > newest_r)
            hit = ST_SEQUENCE;
          if (cmd_num_r + 8'd1 >= count_r) finish = 1'b1;
        end
      end
      default: hit = ST_LONG;
    endcase
  end

  // Resolve the first error, including closing and short checks.
  always_comb begin
    logic [31:0] last_seq;
    last_seq = cmd_done ? seq : prev_seq_r;
    err_nxt = err_r;
    if (err_nxt == ST_OK) err_nxt = hit;
    if (finish && err_nxt == ST_OK && last_seq != newest_nxt) err_nxt = ST_SEQUENCE;
    in_trailing = (phase_r == PH_TRAILING) || finish;
    if (end_of_packet && !in_trailing && err_nxt == ST_OK) err_nxt = ST_SHORT;
  end

  always_comb begin
    rec = '0;
    rec.first_word = seq;
    rec.second_word = tick;
    rec.forward_code = fwd;
    rec.strafe_code = strf;
    rec.yaw_code = yaw;
    rec.pitch_code = pitch;
    rec.button_bits = buttons[3:0];
    rec.weapon_code = weapon;
    vrd = '0;
    vrd.first_word = newest_nxt;
    vrd.second_word = ack_nxt;
    vrd.player_number = player_nxt;
    vrd.count_field = count_nxt;
    vrd.status = err_nxt;
  end

  // Hand results to the queue; a verdict is always the last item pushed.
  always_comb begin
    push_n = 2'd0;
    push0 = rec;
    push0_verdict = 1'b0;
    push1 = vrd;
    if (fire) begin
      if (cmd_done && end_of_packet) push_n = 2'd2;
      else if (cmd_done) push_n = 2'd1;
      else if (end_of_packet) begin
        push_n = 2'd1;
        push0 = vrd;
        push0_verdict = 1'b1;
      end
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      version_r <= 8'd1;
      kind_r <= 8'd0;
      player_lim_r <= 8'd16;
      weapon_lim_r <= 8'd8;
      command_lim_r <= 8'd4;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_VERSION: version_r <= cfg_data;
        REG_KIND:    kind_r <= cfg_data;
        REG_PLAYER:  player_lim_r <= cfg_data;
        REG_WEAPON:  weapon_lim_r <= cfg_data;
        REG_COMMAND: command_lim_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Advance parse state on each accepted beat.
  always_ff @(posedge clk) begin
    if (!rst_n || (fire && end_of_packet)) begin
      phase_r <= PH_HEADER;
      off_r <= '0;
      cmd_num_r <= '0;
      prev_seq_r <= '0;
      newest_r <= '0;
      ack_r <= '0;
      player_r <= '0;
      count_r <= '0;
      asm_r <= '0;
      err_r <= ST_OK;
    end else if (fire) begin
      err_r <= err_nxt;
      newest_r <= newest_nxt;
      ack_r <= ack_nxt;
      player_r <= player_nxt;
      count_r <= count_nxt;
      if (phase_r != PH_TRAILING) off_r <= off_r + 4'd1;
      if (phase_r == PH_COMMANDS) begin
        asm_r <= {data_byte, asm_r[119:8]};
        if (cmd_done) begin
          asm_r <= '0;
          prev_seq_r <= seq;
          cmd_num_r <= cmd_num_r + 8'd1;
        end
      end
      if (finish) phase_r <= PH_TRAILING;
      else if (phase_r == PH_HEADER && off_r == 4'hF) phase_r <= PH_COMMANDS;
    end
  end

endmodule

### src/ipp_queue.sv
// ----------------------------------------------------------------------------
// ipp_queue
// Four-entry result queue between the parser and the output port.
// ----------------------------------------------------------------------------
module ipp_queue import ipp_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic [1:0] push_n,
  input  result_t   push0,
  input  logic      push0_verdict,
  input  result_t   push1,
  output logic [1:0] space,
  output logic      out_valid,
  input  logic      out_ready,
  output result_t   out_item,
  output logic      out_verdict
);

  result_t    mem_r [4];
  logic       vflag_r [4];
  logic [1:0] wp_r, rp_r;
  logic [2:0] cnt_r;
  logic       pop;
  logic [1:0] wp1;

  assign pop = out_valid && out_ready;
  assign out_valid = (cnt_r != 3'd0);
  assign out_item = mem_r[rp_r];
  assign out_verdict = vflag_r[rp_r];
  assign wp1 = wp_r + 2'd1;
  // Report free slots, saturated at two.
  assign space = (cnt_r <= 3'd2) ? 2'd2 : ((cnt_r == 3'd3) ? 2'd1 : 2'd0);

  // Store pushed items; a verdict is always the last item of a push.
  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      mem_r[wp_r] <= push0;
      vflag_r[wp_r] <= push0_verdict;
    end
    if (push_n == 2'd2) begin
      mem_r[wp1] <= push1;
      vflag_r[wp1] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      wp_r <= wp_r + push_n;
      if (pop) rp_r <= rp_r + 2'd1;
      cnt_r <= cnt_r + {1'b0, push_n} - {2'b0, pop};
    end
  end

endmodule

### tb/input_packet_parser_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// input_packet_parser_unit_tb
// Self-checking bench for the input packet parser.
// ----------------------------------------------------------------------------
// Streams packets into the parser byte by byte: a directed table of header
// and framing corner cases first, then random packets, mostly well formed
// with random content and some broken ones. A shadow parser predicts every
// command record and verdict; the results are checked in order, field by
// field, with random idle gaps on both ports.
// ----------------------------------------------------------------------------
module input_packet_parser_unit_tb;
  import ipp_pkg::*;

  typedef struct {
    logic        verdict;
    logic [RESULT_W-1:0] fields;
  } parsed_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         cfg_we = 1'b0;
  logic [2:0]   cfg_index = '0;
  logic [7:0]   cfg_data = '0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [7:0]   in_tdata = '0;
  logic         in_tlast = 1'b0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [143:0] out_tdata;
  logic         out_tuser;

  input_packet_parser_unit uut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow copy of the parser state and registers
  logic [7:0]  r_version, r_kind, r_player, r_weapon, r_command;
  logic [1:0]  sh_phase;
  logic [4:0]  sh_offset;
  logic [7:0]  sh_cmd_num;
  logic [31:0] sh_prev_seq, sh_newest, sh_ack;
  logic [7:0]  sh_player_id, sh_count;
  logic [127:0] sh_cmd;
  logic [2:0]  sh_error;

  parsed_t expected_results[$];
  int mismatches = 0;
  int bytes_sent = 0;

  localparam logic [1:0] PH_HEADER = 2'd0, PH_CMDS = 2'd1, PH_TRAIL = 2'd2;

  function automatic void clear_shadow();
    sh_phase = PH_HEADER; sh_offset = '0; sh_cmd_num = '0; sh_prev_seq = '0;
    sh_newest = '0; sh_ack = '0; sh_player_id = '0; sh_count = '0; sh_cmd = '0;
    sh_error = ST_OK;
  endfunction

  function automatic void flag_error(status_t code);
    if (sh_error == ST_OK) sh_error = code;
  endfunction

  function automatic void close_commands();
    if (sh_prev_seq != sh_newest) flag_error(ST_SEQUENCE);
    sh_phase = PH_TRAIL;
  endfunction

  // Advance the shadow parser by one byte and queue its results
  function automatic void predict_byte(logic [7:0] b, logic eop);
    result_t r;
    parsed_t p;
    logic [3:0] off;
    logic [31:0] seq;
    logic [7:0] fwd, str, btn, wpn;
    off = sh_offset[3:0];
    if (sh_phase == PH_HEADER) begin
      case (off)
        4'd0: if (b != MAGIC_C) flag_error(ST_BAD_ID);
        4'd1: if (b != MAGIC_S) flag_error(ST_BAD_ID);
        4'd2: if (b != r_version) flag_error(ST_BAD_ID);
        4'd3: if (b != r_kind) flag_error(ST_BAD_ID);
        4'd4: begin
          sh_player_id = b;
          if (b >= r_player) flag_error(ST_BAD_FIELD);
        end
        4'd5: begin
          sh_count = b;
          if (b == 0 || b > r_command) flag_error(ST_BAD_FIELD);
        end
        4'd6, 4'd7: if (b != 0) flag_error(ST_BAD_FIELD);
        default: begin
          if (off < 12) sh_newest[8*(off-8) +: 8] = b;
          else sh_ack[8*(off-12) +: 8] = b;
        end
      endcase
      if (off != 4'd15) sh_offset = {1'b0, off + 4'd1};
      else begin
        sh_offset = '0;
        if (sh_count == 0) close_commands();
        else sh_phase = PH_CMDS;
      end
    end else if (sh_phase == PH_CMDS) begin
      sh_cmd[8*off +: 8] = b;
      if (off != 4'd15) sh_offset = {1'b0, off + 4'd1};
      else begin
        seq = sh_cmd[31:0];
        fwd = sh_cmd[71:64]; str = sh_cmd[79:72];
        btn = sh_cmd[119:112]; wpn = sh_cmd[127:120];
        if (wpn >= r_weapon || btn[7:4] != 0 || fwd == AXIS_INVALID ||
            str == AXIS_INVALID)
          flag_error(ST_BAD_CMD);
        else if (seq == 0 || seq <= sh_prev_seq || seq > sh_newest)
          flag_error(ST_SEQUENCE);
        r = '0;
        r.first_word = seq; r.second_word = sh_cmd[63:32];
        r.forward_code = fwd; r.strafe_code = str;
        r.yaw_code = sh_cmd[95:80]; r.pitch_code = sh_cmd[111:96];
        r.button_bits = btn[3:0]; r.weapon_code = wpn;
        p.verdict = 1'b0; p.fields = r;
        expected_results.push_back(p);
        sh_prev_seq = seq;
        sh_cmd_num = sh_cmd_num + 8'd1;
        sh_cmd = '0;
        sh_offset = '0;
        if (sh_cmd_num >= sh_count) close_commands();
      end
    end else begin
      flag_error(ST_LONG);
    end
    if (eop) begin
      if (sh_phase != PH_TRAIL) flag_error(ST_SHORT);
      r = '0;
      r.first_word = sh_newest; r.second_word = sh_ack;
      r.player_number = sh_player_id; r.count_field = sh_count;
      r.status = sh_error;
      p.verdict = 1'b1; p.fields = r;
      expected_results.push_back(p);
      clear_shadow();
    end
  endfunction

  function automatic int short_gap();
    if ($urandom_range(0, 3) != 0) return 0;
    if ($urandom_range(0, 15) == 0) return $urandom_range(10, 40);
    return $urandom_range(1, 3);
  endfunction

  // Consumer side: random stalls, compare each result beat
  int stall_left = 0;
  bit quiet_sink = 1'b0;
  always @(posedge clk) begin
    parsed_t want;
    result_t got;
    if (out_tvalid && out_tready) begin
      got = out_tdata[RESULT_W-1:0];
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat %h", out_tdata);
      end else begin
        want = expected_results.pop_front();
        if (want.verdict !== out_tuser || want.fields !== got) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp verdict=%0b %h, got verdict=%0b %h",
                     want.verdict, want.fields, out_tuser, got);
        end
      end
    end
  end

  always @(negedge clk) begin
    if (quiet_sink) out_tready <= 1'b1;
    else if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_tready <= 1'b1;
      stall_left <= short_gap();
    end
  end

  // Send one byte; hold valid across beats unless a gap is drawn
  task automatic send_byte(input logic [7:0] b, input logic eop);
    int gap;
    gap = short_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= b;
    in_tlast <= eop;
    do @(posedge clk); while (!in_tready);
    predict_byte(b, eop);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic idle_input();
    in_tvalid <= 1'b0;
    in_tlast <= 1'b0;
  endtask

  task automatic drain();
    idle_input();
    while (expected_results.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [7:0] val);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_VERSION: r_version = val;
      REG_KIND:    r_kind = val;
      REG_PLAYER:  r_player = val;
      REG_WEAPON:  r_weapon = val;
      default:     r_command = val;
    endcase
  endtask

  // Build and send a packet; corrupt selects one flaw (0 = well formed)
  task automatic send_packet(input int corrupt);
    logic [7:0] pkt[$];
    logic [31:0] seq, newest, tick;
    logic [7:0] count, w;
    int n, cut;
    count = (r_command == 0) ? 8'd1 : 8'($urandom_range(1, r_command > 4 ? 4 : r_command));
    seq = $urandom_range(1, 1000);
    newest = seq + count - 1;
    if ($urandom_range(0, 3) == 0) newest = newest + $urandom_range(0, 3);
    pkt.push_back(MAGIC_C); pkt.push_back(MAGIC_S);
    pkt.push_back(r_version); pkt.push_back(r_kind);
    pkt.push_back(r_player == 0 ? 8'd0 : 8'($urandom_range(0, r_player - 1)));
    pkt.push_back(count); pkt.push_back(8'h00); pkt.push_back(8'h00);
    for (int i = 0; i < 4; i++) pkt.push_back(newest[8*i +: 8]);
    tick = $urandom;
    for (int i = 0; i < 4; i++) pkt.push_back(tick[8*i +: 8]);
    for (int c = 0; c < count; c++) begin
      if (c == count - 1) seq = newest;
      tick = $urandom;
      for (int i = 0; i < 4; i++) pkt.push_back(seq[8*i +: 8]);
      for (int i = 0; i < 4; i++) pkt.push_back(tick[8*i +: 8]);
      for (int i = 0; i < 6; i++) pkt.push_back(8'($urandom));
      pkt.push_back(8'($urandom_range(0, 15)));
      w = (r_weapon == 0) ? 8'd0 : 8'($urandom_range(0, r_weapon - 1));
      pkt.push_back(w);
      seq = seq + $urandom_range(1, 2);
      if (seq > newest) seq = newest;
    end
    case (corrupt)
      1: pkt[$urandom_range(0, 15)] = 8'($urandom);
      2: pkt[$urandom_range(16, pkt.size() - 1)] = 8'($urandom);
      3: pkt[16 + 8 + $urandom_range(0, 1)] = AXIS_INVALID;
      4: pkt[16 + 14] = 8'($urandom_range(16, 255));
      5: pkt.push_back(8'($urandom));
      default: ;
    endcase
    n = pkt.size();
    cut = (corrupt == 6) ? $urandom_range(1, n - 1) : n;
    for (int i = 0; i < cut; i++) send_byte(pkt[i], i == cut - 1);
  endtask

  // Directed rows: byte, last flag and, where obvious, the expected verdict
  // status (negative: predictor only)
  typedef struct {
    logic [7:0] b;
    logic       eop;
    int         exp_status;
  } row_t;
  row_t dir_rows[$];

  task automatic push_row(input logic [7:0] b, input logic eop, input int exp_status);
    row_t r;
    r.b = b; r.eop = eop; r.exp_status = exp_status;
    dir_rows.push_back(r);
  endtask

  initial begin
    logic [7:0] hdr[16];
    parsed_t last_p;
    result_t last_r;
    int base;
    r_version = 8'd1; r_kind = 8'd0; r_player = 8'd16; r_weapon = 8'd8;
    r_command = 8'd4;
    clear_shadow();
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Lone byte after reset: short packet with bad magic -> bad header id
    push_row(8'hFF, 1'b1, int'(ST_BAD_ID));
    // Zero-count header: bad field, then last sequence check
    hdr = '{8'h43, 8'h53, 8'h01, 8'h00, 8'h0F, 8'h00, 8'h00, 8'h00,
            8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h80};
    foreach (hdr[i]) push_row(hdr[i], i == 15, (i == 15) ? int'(ST_BAD_FIELD) : -1);
    // Trailing byte after a zero-count header: the bad field still wins
    foreach (hdr[i]) push_row(hdr[i], 1'b0, -1);
    push_row(8'h01, 1'b1, int'(ST_BAD_FIELD));
    foreach (dir_rows[i]) begin
      send_byte(dir_rows[i].b, dir_rows[i].eop);
      if (dir_rows[i].exp_status >= 0) begin
        if (expected_results.size() == 0) mismatches++;
        else begin
          last_p = expected_results[$];
          last_r = last_p.fields;
          if (!last_p.verdict || last_r.status != 3'(dir_rows[i].exp_status)) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: row %0d exp status=%0d, got status=%0d",
                       i, dir_rows[i].exp_status, last_r.status);
          end
        end
      end
    end
    drain();
    if (expected_results.size() != 0) mismatches++;

    // Directed well-formed and flawed packets at reset settings
    for (int k = 0; k <= 6; k++) send_packet(k);
    drain();
    base = bytes_sent;

    // Register extremes, then random settings; the first phase pauses fully
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: begin
          write_reg(REG_VERSION, 8'hFF); write_reg(REG_KIND, 8'hFF);
          write_reg(REG_PLAYER, 8'hFF); write_reg(REG_WEAPON, 8'hFF);
          write_reg(REG_COMMAND, 8'hFF);
        end
        1: begin
          write_reg(REG_VERSION, 8'h00); write_reg(REG_KIND, 8'h00);
          write_reg(REG_PLAYER, 8'h01); write_reg(REG_WEAPON, 8'h01);
          write_reg(REG_COMMAND, 8'h01);
        end
        2: write_reg(REG_PLAYER, 8'h00);
        default: begin
          write_reg(REG_VERSION, 8'($urandom)); write_reg(REG_KIND, 8'($urandom));
          write_reg(REG_PLAYER, 8'($urandom_range(1, 255)));
          write_reg(REG_WEAPON, 8'($urandom_range(1, 255)));
          write_reg(REG_COMMAND, 8'($urandom_range(1, 8)));
        end
      endcase
      quiet_sink = (phase == 5);
      while (bytes_sent < base + (1150 - base) * (phase + 1) / 6) begin
        if ($urandom_range(0, 9) == 0) begin
          // noise: raw random bytes with random last flags
          repeat ($urandom_range(1, 20)) send_byte(8'($urandom), $urandom_range(0, 1));
          send_byte(8'($urandom), 1'b1);
        end else if ($urandom_range(0, 2) == 0) send_packet($urandom_range(1, 6));
        else send_packet(0);
        if (phase == 0 && $urandom_range(0, 4) == 0) drain();
      end
      drain();
    end

    if (mismatches == 0 && expected_results.size() == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    #20ms;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
